>>> rtl/core/tspc_pkg.sv
// Shared types, constants and functions for the tile and sprite pixel composer.
package tspc_pkg;

    localparam int unsigned VramAw = 14;
    localparam int unsigned OamAw  = 8;

    // Input action codes.
    localparam logic [1:0] ACT_VRAM   = 2'd0;
    localparam logic [1:0] ACT_OAM    = 2'd1;
    localparam logic [1:0] ACT_RENDER = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCROLL = 2'd0;
    localparam logic [1:0] CFG_FINE_X = 2'd1;
    localparam logic [1:0] CFG_CTRL   = 2'd2;

    localparam logic [13:0] PAL_BASE = 14'h3F00;

    // One classified item passed from the front part to the back part.
    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] mem_address;
        logic [7:0]  write_data;
        logic [7:0]  screen_x;
        logic [7:0]  screen_y;
    } t_item;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_NT,
        S_AT,
        S_BLO,
        S_BHI,
        S_Y,
        S_TID,
        S_ATTR,
        S_X,
        S_SLO,
        S_SHI,
        S_PAL,
        S_RGB,
        S_OUT
    } t_state;

    // Fixed system colour table.
    function automatic logic [23:0] colour_lookup(input logic [5:0] idx);
        logic [23:0] c;
        case (idx)
            6'd0: c = 24'h7C7C7C;  6'd1: c = 24'h0000FC;  6'd2: c = 24'h0000BC;
            6'd3: c = 24'h4428BC;  6'd4: c = 24'h940084;  6'd5: c = 24'hA80020;
            6'd6: c = 24'hA81000;  6'd7: c = 24'h881400;  6'd8: c = 24'h503000;
            6'd9: c = 24'h007800;  6'd10: c = 24'h006800; 6'd11: c = 24'h005800;
            6'd12: c = 24'h004058; 6'd16: c = 24'hBCBCBC; 6'd17: c = 24'h0078F8;
            6'd18: c = 24'h0058F8; 6'd19: c = 24'h6844FC; 6'd20: c = 24'hD800CC;
            6'd21: c = 24'hE40058; 6'd22: c = 24'hF83800; 6'd23: c = 24'hE45C10;
            6'd24: c = 24'hAC7C00; 6'd25: c = 24'h00B800; 6'd26: c = 24'h00A800;
            6'd27: c = 24'h00A844; 6'd28: c = 24'h008888; 6'd32: c = 24'hF8F8F8;
            6'd33: c = 24'h3CBCFC; 6'd34: c = 24'h6888FC; 6'd35: c = 24'h9878F8;
            6'd36: c = 24'hF878F8; 6'd37: c = 24'hF85898; 6'd38: c = 24'hF87858;
            6'd39: c = 24'hFCA044; 6'd40: c = 24'hF8B800; 6'd41: c = 24'hB8F818;
            6'd42: c = 24'h58D854; 6'd43: c = 24'h58F898; 6'd44: c = 24'h00E8D8;
            6'd45: c = 24'h787878; 6'd48: c = 24'hFCFCFC; 6'd49: c = 24'hA4E4FC;
            6'd50: c = 24'hB8B8F8; 6'd51: c = 24'hD8B8F8; 6'd52: c = 24'hF8B8F8;
            6'd53: c = 24'hF8A4C0; 6'd54: c = 24'hF0D0B0; 6'd55: c = 24'hFCE0A8;
            6'd56: c = 24'hF8D878; 6'd57: c = 24'hD8F878; 6'd58: c = 24'hB8F8B8;
            6'd59: c = 24'hB8F8D8; 6'd60: c = 24'h00FCFC; 6'd61: c = 24'hF8D8F8;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/tile_sprite_pixel_composer.sv
// Top level of the tile and sprite pixel composer.
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tuser: action; tdata: mem_address, write_data, x, y
//  m_axis  | out | m_axis_tvalid/tready   | tdata: red, green, blue, background_opaque
//  cfg     | in  | i_cfg_we               | i_cfg_index, i_cfg_data
// A write item is taken while the back part is idle; a render scans the sprite slots in
// turn and stops at the first winning sprite, reading each memory one address at a time.
// Reset is synchronous and active low; memory contents are not cleared.
// A two-item queue lets input be taken while the back part renders or the output stalls.
module tile_sprite_pixel_composer #(
    parameter int unsigned SPRITE_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // action
    input  logic [39:0] s_axis_tdata,  // mem_address, write_data, screen_x, screen_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // red, green, blue, background_opaque
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    import tspc_pkg::*;

    logic [14:0] r_scroll;
    logic [2:0]  r_fine_x;
    logic [7:0]  r_ctrl;
    t_item       w_in, w_q;
    logic        w_qv, w_pop;
    logic [24:0] w_pix;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll <= '0;
            r_fine_x <= '0;
            r_ctrl   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCROLL: r_scroll <= i_cfg_data;
                CFG_FINE_X: r_fine_x <= i_cfg_data[2:0];
                CFG_CTRL:   r_ctrl   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_in.action      = s_axis_tuser;
    assign w_in.mem_address = s_axis_tdata[13:0];
    assign w_in.write_data  = s_axis_tdata[21:14];
    assign w_in.screen_x    = s_axis_tdata[29:22];
    assign w_in.screen_y    = s_axis_tdata[37:30];

    tspc_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(w_in),
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_item(w_q)
    );

    tspc_back #(.SpriteSlots(SPRITE_SLOTS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_qv), .o_q_pop(w_pop), .i_item(w_q),
        .i_scroll(r_scroll), .i_fine_x(r_fine_x), .i_ctrl(r_ctrl),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_pix)
    );

    assign m_axis_tdata = {7'd0, w_pix[24], w_pix[7:0], w_pix[15:8], w_pix[23:16]};

endmodule

>>> rtl/core/tspc_front.sv
// Front part: input acceptance, action filtering and a two-entry item queue.
module tspc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tspc_pkg::t_item i_item,
    output logic            o_q_valid,
    input  logic            i_q_pop,
    output tspc_pkg::t_item o_q_item
);
    import tspc_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_keep;

    // Unused action codes are dropped here and never reach the back part.
    assign o_ready   = (r_cnt != 2'd2);
    assign w_keep    = (i_item.action == ACT_VRAM) || (i_item.action == ACT_OAM)
                    || (i_item.action == ACT_RENDER);
    assign w_push    = i_valid && o_ready && w_keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !w_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_cnt != 2'd0)) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

endmodule

>>> rtl/core/tspc_back.sv
// Back part: memory writes and the per-pixel background and sprite sequencer.
module tspc_back #(
    parameter int unsigned SpriteSlots = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  tspc_pkg::t_item i_item,
    input  logic [14:0]     i_scroll,
    input  logic [2:0]      i_fine_x,
    input  logic [7:0]      i_ctrl,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [24:0]     o_data
);
    import tspc_pkg::*;

    localparam logic [6:0] LastSlot = 7'(SpriteSlots - 1);

    logic [7:0] r_vram [1 << VramAw];
    logic [7:0] r_oam  [1 << OamAw];

    t_state r_state, n_state;
    logic [VramAw-1:0] n_vaddr;
    logic [OamAw-1:0]  n_oaddr;
    logic [7:0] r_vdata, r_odata;

    // Per-pixel working registers.
    logic [8:0] r_px;
    logic [4:0] r_tx, r_ty;
    logic [1:0] r_nt;
    logic [7:0] r_tile, r_attr, r_lo;
    logic [1:0] r_bgpix, r_pix, r_pal;
    logic [7:0] r_sy_top, r_tid, r_sat;
    logic [6:0] r_slot_cnt;
    logic       r_spr_hit;
    logic [5:0] r_cidx;
    logic [24:0] r_out;
    logic       r_oval;

    // Derived combinational values.
    logic [8:0] w_px;
    logic [4:0] w_ty;
    logic [5:0] w_tyfull;
    logic [13:0] w_ntbase, w_bgrow;
    logic [8:0] w_dy, w_dx;
    logic [3:0] w_r;
    logic [13:0] w_spa;
    logic [2:0] w_bit_bg, w_sbit;
    logic       w_cover_y, w_cover_x;
    logic [4:0] w_poff;
    logic       w_tall;
    logic       w_last;
    logic [1:0] w_sp;
    logic       w_sp_hit;

    assign w_tall   = i_ctrl[5];
    assign w_px     = {1'b0, i_item.screen_x} + {1'b0, i_scroll[4:0], 3'b000} + {6'd0, i_fine_x};
    assign w_tyfull = {1'b0, i_scroll[9:5]} + {1'b0, i_item.screen_y[7:3]};
    // Tile row wraps modulo 30; the sum can reach two full wraps.
    assign w_ty     = (w_tyfull >= 6'd60) ? 5'(w_tyfull - 6'd60)
                    : (w_tyfull >= 6'd30) ? 5'(w_tyfull - 6'd30) : w_tyfull[4:0];
    assign w_ntbase = 14'h2000 + {2'b00, r_nt, 10'd0};
    assign w_bgrow  = {1'b0, i_ctrl[4], 12'd0} + {2'b00, r_tile, 4'd0}
                    + {11'd0, i_item.screen_y[2:0]};
    assign w_bit_bg = 3'd7 - r_px[2:0];

    // Sprite row and column within the sprite.
    assign w_dy = {1'b0, i_item.screen_y} - ({1'b0, r_sy_top} + 9'd1);
    assign w_dx = {1'b0, i_item.screen_x} - {1'b0, r_odata};
    assign w_cover_y = (({1'b0, r_sy_top} + 9'd1) < 9'd240) && (i_item.screen_y < 8'd240)
                    && ({1'b0, i_item.screen_y} >= ({1'b0, r_sy_top} + 9'd1))
                    && (w_dy < (w_tall ? 9'd16 : 9'd8));
    assign w_cover_x = (i_item.screen_x >= r_odata) && (w_dx < 9'd8);
    assign w_r = r_sat[7] ? ((w_tall ? 4'd15 : 4'd7) - w_dy[3:0]) : w_dy[3:0];
    assign w_spa = w_tall
        ? ({1'b0, r_tid[0], 12'd0} + {2'b00, r_tid[7:1], w_r[3], 4'd0} + {10'd0, 1'b0, w_r[2:0]})
        : ({1'b0, i_ctrl[3], 12'd0} + {2'b00, r_tid, 4'd0} + {10'd0, 1'b0, w_r[2:0]});
    assign w_sbit = r_sat[6] ? r_px[2:0] : 3'd7 - r_px[2:0];
    // Sprite palettes sit in the upper half of the palette area.
    assign w_poff = (r_pix == 2'd0) ? 5'd0 : {r_spr_hit, r_pal, r_pix};
    assign w_last = (r_slot_cnt == LastSlot);

    // A sprite wins when opaque and not hidden behind an opaque background.
    assign w_sp     = {r_vdata[w_sbit], r_lo[w_sbit]};
    assign w_sp_hit = (w_sp != 2'd0) && !(r_sat[5] && r_bgpix != 2'd0);

    // Memories: one write port and one read port each, registered read data.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid && i_item.action == ACT_VRAM) begin
            r_vram[i_item.mem_address] <= i_item.write_data;
        end
        r_vdata <= r_vram[n_vaddr];
    end
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid && i_item.action == ACT_OAM) begin
            r_oam[i_item.mem_address[7:0]] <= i_item.write_data;
        end
        r_odata <= r_oam[n_oaddr];
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Next state, memory addresses and queue pop.
    always_comb begin
        n_state = r_state;
        n_vaddr = '0;
        n_oaddr = '0;
        o_q_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_item.action == ACT_RENDER) n_state = S_NT;
                    else o_q_pop = 1'b1;
                end
            end
            S_NT: begin
                n_vaddr = 14'(w_ntbase + {4'd0, r_ty, r_tx});
                n_state = S_AT;
            end
            S_AT: begin
                n_vaddr = 14'(w_ntbase + 14'h03C0 + {6'd0, r_ty[4:2], r_tx[4:2]});
                n_state = S_BLO;
            end
            S_BLO: begin
                n_vaddr = w_bgrow;
                n_state = S_BHI;
            end
            S_BHI: begin
                n_vaddr = 14'(w_bgrow + 14'd8);
                n_oaddr = {r_slot_cnt[5:0], 2'd0};
                n_state = S_Y;
            end
            S_Y: begin
                n_oaddr = {r_slot_cnt[5:0], 2'd1};
                n_state = S_TID;
            end
            S_TID: begin
                n_oaddr = {r_slot_cnt[5:0], 2'd2};
                n_state = S_ATTR;
            end
            S_ATTR: begin
                n_oaddr = {r_slot_cnt[5:0], 2'd3};
                n_state = S_X;
            end
            S_X: begin
                n_vaddr = w_spa;
                if (w_cover_y && w_cover_x) n_state = S_SLO;
                else if (w_last) n_state = S_PAL;
                else n_state = S_Y;
                n_oaddr = {r_slot_cnt[5:0] + 6'd1, 2'd0};
            end
            S_SLO: begin
                n_vaddr = 14'(w_spa + 14'd8);
                n_state = S_SHI;
            end
            // A transparent or hidden sprite lets the scan go on to the next slot.
            S_SHI: begin
                n_oaddr = {r_slot_cnt[5:0] + 6'd1, 2'd0};
                if (w_sp_hit || w_last) n_state = S_PAL;
                else n_state = S_Y;
            end
            S_PAL: begin
                n_vaddr = PAL_BASE + {9'd0, w_poff};
                n_state = S_RGB;
            end
            S_RGB: n_state = S_OUT;
            S_OUT: begin
                if (!r_oval || i_ready) begin
                    o_q_pop = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers advanced by the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px  <= w_px;
                r_tx  <= w_px[7:3];
                r_ty  <= w_ty;
                r_nt  <= {i_scroll[11], i_scroll[10] ^ w_px[8]};
                r_slot_cnt <= 7'd0;
                r_spr_hit <= 1'b0;
            end
            S_AT:  r_tile <= r_vdata;
            S_BLO: r_attr <= r_vdata;
            S_BHI: r_lo   <= r_vdata;
            S_Y: begin
                r_sy_top <= r_odata;
                if (r_slot_cnt == 7'd0) begin
                    r_bgpix <= {r_vdata[w_bit_bg], r_lo[w_bit_bg]};
                    r_pix   <= {r_vdata[w_bit_bg], r_lo[w_bit_bg]};
                    r_pal   <= 2'(r_attr >> {r_ty[1], r_tx[1], 1'b0});
                end
            end
            S_TID:  r_tid <= r_odata;
            S_ATTR: r_sat <= r_odata;
            S_X: begin
                if (w_cover_y && w_cover_x) begin
                    r_px <= {6'd0, w_dx[2:0]};
                end else begin
                    r_slot_cnt <= r_slot_cnt + 7'd1;
                end
            end
            S_SLO: r_lo <= r_vdata;
            S_SHI: begin
                r_slot_cnt <= r_slot_cnt + 7'd1;
                if (w_sp_hit) begin
                    r_spr_hit <= 1'b1;
                    r_pix <= w_sp;
                    r_pal <= r_sat[1:0];
                end
            end
            S_PAL: ;
            S_RGB: r_cidx <= r_vdata[5:0];
            default: ;
        endcase
    end

    // Output register; the pixel holds until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else begin
            if (r_oval && i_ready) r_oval <= 1'b0;
            if (r_state == S_OUT && (!r_oval || i_ready)) begin
                r_oval <= 1'b1;
                r_out  <= {r_bgpix != 2'd0, colour_lookup(r_cidx)};
            end
        end
    end

    assign o_valid = r_oval;
    assign o_data  = r_out;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE || r_state == S_OUT)) else $error("pop mid-render");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_oval)) |-> ($past(r_state) == S_OUT)) else $error("stray pixel");
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_cnt <= 7'(SpriteSlots)) else $error("slot count overrun");

endmodule
